/* rtl/fbct_pkg.sv */
// Shared types and constants for the frustum box cull test.
// Used by fbct_ctrl, fbct_datapath and frustum_box_cull_test; no dependencies.
package fbct_pkg;

	localparam int COORD_W        = 32;  // signed Q16.16 coordinates and plane terms
	localparam int PROD_W         = 2 * COORD_W;
	localparam int PLANE_IDX_W    = 3;
	localparam int IDX_CMP_W      = PLANE_IDX_W + 1;
	localparam int NUM_PLANES_DEF = 6;
	localparam int PIPE_DEPTH     = 4;   // multiply, max select, partial sum, final sum

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TEST = 1'b1;

	typedef struct packed {
		logic                   start;    // test item accepted: latch box, clear verdict
		logic                   load;     // load item accepted: write plane slot
		logic                   issue;    // feed one plane into the pipe
		logic [PLANE_IDX_W-1:0] sel;      // plane slot being fed
		logic                   capture;  // move verdict into the output register
	} fbct_cmd_t;

endpackage

/* rtl/fbct_datapath.sv */
// Datapath: plane store, box registers, four-stage plane evaluation pipe, verdict.
// Depends on fbct_pkg; driven by fbct_ctrl through fbct_cmd_t.
module fbct_datapath import fbct_pkg::*; #(
	parameter int NUM_PLANES = NUM_PLANES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fbct_cmd_t                     cmd,
	input  logic [PLANE_IDX_W-1:0]        plane_index,
	input  logic signed [COORD_W-1:0]     plane_nx,
	input  logic signed [COORD_W-1:0]     plane_ny,
	input  logic signed [COORD_W-1:0]     plane_nz,
	input  logic signed [COORD_W-1:0]     plane_offset,
	input  logic signed [COORD_W-1:0]     box_min_x,
	input  logic signed [COORD_W-1:0]     box_min_y,
	input  logic signed [COORD_W-1:0]     box_min_z,
	input  logic signed [COORD_W-1:0]     box_max_x,
	input  logic signed [COORD_W-1:0]     box_max_y,
	input  logic signed [COORD_W-1:0]     box_max_z,
	output logic                          visible
);

	localparam int SEL_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

	logic signed [COORD_W-1:0] nx_q [NUM_PLANES];
	logic signed [COORD_W-1:0] ny_q [NUM_PLANES];
	logic signed [COORD_W-1:0] nz_q [NUM_PLANES];
	logic signed [COORD_W-1:0] d_q  [NUM_PLANES];

	logic signed [COORD_W-1:0] xmin_q, ymin_q, zmin_q, xmax_q, ymax_q, zmax_q;

	logic signed [COORD_W-1:0] rd_nx, rd_ny, rd_nz, rd_d;
	logic                      rd_ok;

	logic signed [PROD_W-1:0]  px0_s1, px1_s1, py0_s1, py1_s1, pz0_s1, pz1_s1;
	logic signed [COORD_W-1:0] d_s1, d_s2;
	logic signed [PROD_W-1:0]  mx_s2, my_s2, mz_s2;
	logic signed [PROD_W:0]    sxy_s3, zd_s3;
	logic signed [PROD_W+1:0]  sum;
	logic                      inside_s4;
	logic                      v_s1, v_s2, v_s3, v_s4;
	logic                      culled_q, visible_q;
	logic                      wr_ok;

	assign wr_ok = IDX_CMP_W'(plane_index) < IDX_CMP_W'(NUM_PLANES);
	assign rd_ok = IDX_CMP_W'(cmd.sel) < IDX_CMP_W'(NUM_PLANES);

	// Slots beyond the store read as zero; they are never issued.
	assign rd_nx = rd_ok ? nx_q[cmd.sel[SEL_W-1:0]] : '0;
	assign rd_ny = rd_ok ? ny_q[cmd.sel[SEL_W-1:0]] : '0;
	assign rd_nz = rd_ok ? nz_q[cmd.sel[SEL_W-1:0]] : '0;
	assign rd_d  = rd_ok ? d_q[cmd.sel[SEL_W-1:0]]  : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				nx_q[i] <= '0;
				ny_q[i] <= '0;
				nz_q[i] <= '0;
				d_q[i]  <= '0;
			end
		end else if (cmd.load && wr_ok) begin
			nx_q[plane_index[SEL_W-1:0]] <= plane_nx;
			ny_q[plane_index[SEL_W-1:0]] <= plane_ny;
			nz_q[plane_index[SEL_W-1:0]] <= plane_nz;
			d_q[plane_index[SEL_W-1:0]]  <= plane_offset;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			xmin_q <= box_min_x;
			ymin_q <= box_min_y;
			zmin_q <= box_min_z;
			xmax_q <= box_max_x;
			ymax_q <= box_max_y;
			zmax_q <= box_max_z;
		end
	end

	// Best corner per plane: take the larger product on each axis independently.
	assign sum = {sxy_s3[PROD_W], sxy_s3} + {zd_s3[PROD_W], zd_s3};

	always_ff @(posedge clk) begin
		px0_s1 <= rd_nx * xmin_q;
		px1_s1 <= rd_nx * xmax_q;
		py0_s1 <= rd_ny * ymin_q;
		py1_s1 <= rd_ny * ymax_q;
		pz0_s1 <= rd_nz * zmin_q;
		pz1_s1 <= rd_nz * zmax_q;
		d_s1   <= rd_d;

		mx_s2 <= (px0_s1 > px1_s1) ? px0_s1 : px1_s1;
		my_s2 <= (py0_s1 > py1_s1) ? py0_s1 : py1_s1;
		mz_s2 <= (pz0_s1 > pz1_s1) ? pz0_s1 : pz1_s1;
		d_s2  <= d_s1;

		sxy_s3 <= {mx_s2[PROD_W-1], mx_s2} + {my_s2[PROD_W-1], my_s2};
		zd_s3  <= {mz_s2[PROD_W-1], mz_s2}
			+ {{(PROD_W + 1 - COORD_W - 16){d_s2[COORD_W-1]}}, d_s2, 16'b0};

		inside_s4 <= !sum[PROD_W+1] && (sum != '0);

		if (cmd.capture) begin
			visible_q <= !culled_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			culled_q <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (cmd.start) begin
				culled_q <= 1'b0;
			end else if (v_s4 && !inside_s4) begin
				culled_q <= 1'b1;
			end
		end
	end

	assign visible = visible_q;

endmodule

/* rtl/fbct_ctrl.sv */
// Controller: accepts items, steps through the planes, drains the pipe, owns out_valid.
// Depends on fbct_pkg; drives fbct_datapath through fbct_cmd_t.
module fbct_ctrl import fbct_pkg::*; #(
	parameter int NUM_PLANES = NUM_PLANES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      action,
	output logic      out_valid,
	input  logic      out_ready,
	output fbct_cmd_t cmd
);

	localparam int LAST  = NUM_PLANES + PIPE_DEPTH - 1;
	localparam int CNT_W = $clog2(LAST + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             accept;
	logic             out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign cmd.start   = accept && (action == ACT_TEST);
	assign cmd.load    = accept && (action == ACT_LOAD);
	assign cmd.issue   = (state_q == ST_RUN) && (cnt_q < CNT_W'(NUM_PLANES));
	assign cmd.sel     = PLANE_IDX_W'(cnt_q);
	assign cmd.capture = (state_q == ST_HOLD) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						cnt_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					// Issue every plane, then wait for the last one to leave the pipe.
					if (cnt_q == CNT_W'(LAST)) begin
						state_q <= ST_HOLD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/frustum_box_cull_test.sv */
// Top level of the frustum box cull test: controller plus datapath.
// Depends on fbct_pkg, fbct_ctrl and fbct_datapath.
//
// A load item (action 0) writes one of NUM_PLANES plane slots; a slot index at or above
// NUM_PLANES is dropped. A test item (action 1) gives one result on visible: 0 when some
// plane has all eight box corners on or behind it, else 1. The sums are exact. While a
// test runs, one plane per cycle enters a four-stage pipe built around six 32x32
// multiplier lanes, then the pipe drains and the verdict moves into the output register;
// only then can the next item be accepted. in_ready is low while a test is in flight; a
// waiting result does not block loads or a new test, only the hand-over of the following
// verdict. All slots reset to zero, so a test before the planes are loaded reports culled.
module frustum_box_cull_test import fbct_pkg::*; #(
	parameter int NUM_PLANES = NUM_PLANES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      action,
	input  logic [PLANE_IDX_W-1:0]    plane_index,
	input  logic signed [COORD_W-1:0] plane_nx,
	input  logic signed [COORD_W-1:0] plane_ny,
	input  logic signed [COORD_W-1:0] plane_nz,
	input  logic signed [COORD_W-1:0] plane_offset,
	input  logic signed [COORD_W-1:0] box_min_x,
	input  logic signed [COORD_W-1:0] box_min_y,
	input  logic signed [COORD_W-1:0] box_min_z,
	input  logic signed [COORD_W-1:0] box_max_x,
	input  logic signed [COORD_W-1:0] box_max_y,
	input  logic signed [COORD_W-1:0] box_max_z,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      visible
);

	fbct_cmd_t cmd;

	fbct_ctrl #(
		.NUM_PLANES(NUM_PLANES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	fbct_datapath #(
		.NUM_PLANES(NUM_PLANES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.plane_index  (plane_index),
		.plane_nx     (plane_nx),
		.plane_ny     (plane_ny),
		.plane_nz     (plane_nz),
		.plane_offset (plane_offset),
		.box_min_x    (box_min_x),
		.box_min_y    (box_min_y),
		.box_min_z    (box_min_z),
		.box_max_x    (box_max_x),
		.box_max_y    (box_max_y),
		.box_max_z    (box_max_z),
		.visible      (visible)
	);

`ifndef ASSERT_OFF
	a_no_issue_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !cmd.issue)
		else $error("plane issued while the block takes items");

	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (IDX_CMP_W'(cmd.sel) < IDX_CMP_W'(NUM_PLANES)))
		else $error("issued plane slot beyond the store");

	a_busy_after_test: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !in_ready && !cmd.capture)
		else $error("test item did not occupy the block");

	a_capture_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> out_valid)
		else $error("captured verdict not presented");
`endif

endmodule

/* bench/tb_frustum_box_cull_test.sv */
// Self-checking bench for frustum_box_cull_test: plane loads and box tests with an exact
// 128-bit plane-distance predictor, random idling on both handshakes.
// Depends on fbct_pkg and frustum_box_cull_test.
module tb_frustum_box_cull_test;
	import fbct_pkg::*;

	localparam int PLANES    = NUM_PLANES_DEF;
	localparam int DIR_ROWS  = 24;
	localparam int RAND_ITEMS = 550;
	localparam logic signed [COORD_W-1:0] Q_ONE  = 32'sh0001_0000;
	localparam logic signed [COORD_W-1:0] Q_TEN  = 32'sh000A_0000;
	localparam logic signed [COORD_W-1:0] Q_MIN  = 32'sh8000_0000;
	localparam logic signed [COORD_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;

	typedef struct {
		logic                      action;
		logic [PLANE_IDX_W-1:0]    index;
		logic signed [COORD_W-1:0] nx, ny, nz, offset;
		logic signed [COORD_W-1:0] min_x, min_y, min_z, max_x, max_y, max_z;
	} cull_item_t;

	typedef struct {
		cull_item_t it;
		bit         typed;  // verdict written in the row
		bit         vis;
	} cull_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic                      action;
	logic [PLANE_IDX_W-1:0]    plane_index;
	logic signed [COORD_W-1:0] plane_nx, plane_ny, plane_nz, plane_offset;
	logic signed [COORD_W-1:0] box_min_x, box_min_y, box_min_z;
	logic signed [COORD_W-1:0] box_max_x, box_max_y, box_max_z;
	logic                      out_valid;
	logic                      out_ready;
	logic                      visible;

	logic signed [COORD_W-1:0] nx_tab [PLANES];
	logic signed [COORD_W-1:0] ny_tab [PLANES];
	logic signed [COORD_W-1:0] nz_tab [PLANES];
	logic signed [COORD_W-1:0] d_tab  [PLANES];

	bit          verdicts_due [$];
	int unsigned mismatches;
	bit          steady;
	cull_row_t   dir_tab [DIR_ROWS];

	frustum_box_cull_test uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.plane_index  (plane_index),
		.plane_nx     (plane_nx),
		.plane_ny     (plane_ny),
		.plane_nz     (plane_nz),
		.plane_offset (plane_offset),
		.box_min_x    (box_min_x),
		.box_min_y    (box_min_y),
		.box_min_z    (box_min_z),
		.box_max_x    (box_max_x),
		.box_max_y    (box_max_y),
		.box_max_z    (box_max_z),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.visible      (visible)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("frustum_box_cull_test: mismatch");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t: %s", $time, what);
	endtask

	// Exact plane test: a box survives a plane when some corner has distance > 0.
	function automatic bit box_visible(input cull_item_t it);
		logic signed [127:0] xs [2], ys [2], zs [2];
		logic signed [127:0] a, b, c, d, score;
		bit hit;
		xs[0] = it.min_x; ys[0] = it.min_y; zs[0] = it.min_z;
		xs[1] = it.max_x; ys[1] = it.max_y; zs[1] = it.max_z;
		for (int p = 0; p < PLANES; p++) begin
			a = nx_tab[p];
			b = ny_tab[p];
			c = nz_tab[p];
			d = d_tab[p];
			hit = 1'b0;
			for (int k = 0; k < 8; k++) begin
				score = a * xs[k[2]] + b * ys[k[1]] + c * zs[k[0]] + (d <<< 16);
				if (score > 0)
					hit = 1'b1;
			end
			if (!hit)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic cull_item_t raw_item();
		cull_item_t it;
		it.action = 1'($urandom_range(0, 1));
		it.index  = PLANE_IDX_W'($urandom_range(0, 7));
		it.nx     = $urandom;
		it.ny     = $urandom;
		it.nz     = $urandom;
		it.offset = $urandom;
		it.min_x  = $urandom;
		it.min_y  = $urandom;
		it.min_z  = $urandom;
		it.max_x  = $urandom;
		it.max_y  = $urandom;
		it.max_z  = $urandom;
		return it;
	endfunction

	function automatic cull_item_t mk_load(input int idx, input logic signed [31:0] x,
			input logic signed [31:0] y, input logic signed [31:0] z,
			input logic signed [31:0] d);
		cull_item_t it;
		it        = raw_item();
		it.action = ACT_LOAD;
		it.index  = PLANE_IDX_W'(idx);
		it.nx     = x;
		it.ny     = y;
		it.nz     = z;
		it.offset = d;
		return it;
	endfunction

	function automatic cull_item_t mk_test(input logic signed [31:0] x0,
			input logic signed [31:0] y0, input logic signed [31:0] z0,
			input logic signed [31:0] x1, input logic signed [31:0] y1,
			input logic signed [31:0] z1);
		cull_item_t it;
		it        = raw_item();
		it.action = ACT_TEST;
		it.min_x  = x0;
		it.min_y  = y0;
		it.min_z  = z0;
		it.max_x  = x1;
		it.max_y  = y1;
		it.max_z  = z1;
		return it;
	endfunction

	// Q16.16 value uniform in [-span_int, +span_int].
	function automatic logic signed [31:0] near_q(input int unsigned span_int);
		int unsigned span;
		span = span_int << 16;
		return int'($urandom_range(0, 2 * span)) - int'(span);
	endfunction

	function automatic cull_item_t random_item();
		cull_item_t it;
		int unsigned pick;
		it   = raw_item();
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			it.action = ACT_LOAD;
			// mostly planes that keep the origin inside; the rest is raw noise
			if (pick < 20) begin
				it.index  = PLANE_IDX_W'($urandom_range(0, PLANES - 1));
				it.nx     = near_q(2);
				it.ny     = near_q(2);
				it.nz     = near_q(2);
				it.offset = $urandom_range(1, 200 << 16);
			end
		end else begin
			it.action = ACT_TEST;
			if (pick < 85) begin
				it.min_x = near_q(300);
				it.min_y = near_q(300);
				it.min_z = near_q(300);
				it.max_x = near_q(300);
				it.max_y = near_q(300);
				it.max_z = near_q(300);
			end else if (pick >= 95) begin
				it.min_x = near_q(300);
				it.min_y = near_q(300);
				it.min_z = near_q(300);
				it.max_x = it.min_x;
				it.max_y = it.min_y;
				it.max_z = it.min_z;
			end
		end
		return it;
	endfunction

	task automatic send_item(input cull_item_t it, input bit typed, input bit vis);
		bit exp_vis;
		in_valid     = 1'b1;
		action       = it.action;
		plane_index  = it.index;
		plane_nx     = it.nx;
		plane_ny     = it.ny;
		plane_nz     = it.nz;
		plane_offset = it.offset;
		box_min_x    = it.min_x;
		box_min_y    = it.min_y;
		box_min_z    = it.min_z;
		box_max_x    = it.max_x;
		box_max_y    = it.max_y;
		box_max_z    = it.max_z;
		do @(posedge clk); while (!in_ready);
		if (it.action == ACT_TEST) begin
			exp_vis      = typed ? vis : box_visible(it);
			verdicts_due = {verdicts_due, exp_vis};
		end else if (it.index < PLANES) begin
			nx_tab[it.index] = it.nx;
			ny_tab[it.index] = it.ny;
			nz_tab[it.index] = it.nz;
			d_tab[it.index]  = it.offset;
		end
		@(negedge clk);
		if (!steady && $urandom_range(0, 99) < 30) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	always @(negedge clk)
		out_ready <= steady || ($urandom_range(0, 99) >= 30);

	always @(posedge clk) begin
		bit want;
		if (arst_n && out_valid && out_ready) begin
			if (verdicts_due.size() == 0) begin
				report_mismatch($sformatf("visible=%b with no test pending", visible));
			end else begin
				want = verdicts_due.pop_front();
				if (visible !== want)
					report_mismatch($sformatf("visible got %b want %b", visible, want));
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		action       = ACT_LOAD;
		plane_index  = '0;
		plane_nx     = '0;
		plane_ny     = '0;
		plane_nz     = '0;
		plane_offset = '0;
		box_min_x    = '0;
		box_min_y    = '0;
		box_min_z    = '0;
		box_max_x    = '0;
		box_max_y    = '0;
		box_max_z    = '0;
		mismatches   = 0;
		steady       = 1'b0;
		for (int p = 0; p < PLANES; p++) begin
			nx_tab[p] = '0;
			ny_tab[p] = '0;
			nz_tab[p] = '0;
			d_tab[p]  = '0;
		end

		// unloaded planes cull everything
		dir_tab[0]  = '{mk_test(0, 0, 0, Q_ONE, Q_ONE, Q_ONE), 1, 0};
		dir_tab[1]  = '{mk_test(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX), 1, 0};
		// out-of-range slots are dropped
		dir_tab[2]  = '{mk_load(6, Q_ONE, Q_ONE, Q_ONE, Q_TEN), 0, 0};
		dir_tab[3]  = '{mk_load(7, Q_ONE, Q_ONE, Q_ONE, Q_TEN), 0, 0};
		dir_tab[4]  = '{mk_test(0, 0, 0, Q_ONE, Q_ONE, Q_ONE), 1, 0};
		// cube of half-size ten around the origin
		dir_tab[5]  = '{mk_load(0, Q_ONE, 0, 0, Q_TEN), 0, 0};
		dir_tab[6]  = '{mk_load(1, -Q_ONE, 0, 0, Q_TEN), 0, 0};
		dir_tab[7]  = '{mk_load(2, 0, Q_ONE, 0, Q_TEN), 0, 0};
		dir_tab[8]  = '{mk_load(3, 0, -Q_ONE, 0, Q_TEN), 0, 0};
		dir_tab[9]  = '{mk_load(4, 0, 0, Q_ONE, Q_TEN), 0, 0};
		dir_tab[10] = '{mk_load(5, 0, 0, -Q_ONE, Q_TEN), 0, 0};
		dir_tab[11] = '{mk_test(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE), 1, 1};
		// box touching a plane from behind is culled; one step further in is not
		dir_tab[12] = '{mk_test(-2 * Q_TEN, -Q_ONE, -Q_ONE, -Q_TEN, Q_ONE, Q_ONE), 1, 0};
		dir_tab[13] = '{mk_test(-2 * Q_TEN, -Q_ONE, -Q_ONE, -Q_TEN + 1, Q_ONE, Q_ONE), 0, 0};
		// min above max, used as given
		dir_tab[14] = '{mk_test(5 * Q_ONE, 5 * Q_ONE, 5 * Q_ONE,
				-5 * Q_ONE, -5 * Q_ONE, -5 * Q_ONE), 0, 0};
		dir_tab[15] = '{mk_test(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX), 0, 0};
		dir_tab[16] = '{mk_test(0, 0, 2 * Q_TEN, Q_ONE, Q_ONE, 3 * Q_TEN), 0, 0};
		// extreme plane terms
		dir_tab[17] = '{mk_load(0, Q_MIN, Q_MAX, Q_MIN, Q_MAX), 0, 0};
		dir_tab[18] = '{mk_load(1, Q_MAX, Q_MIN, Q_MAX, Q_MIN), 0, 0};
		dir_tab[19] = '{mk_test(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX), 0, 0};
		dir_tab[20] = '{mk_test(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN), 0, 0};
		dir_tab[21] = '{mk_test(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX), 0, 0};
		dir_tab[22] = '{mk_load(0, Q_ONE, 0, 0, Q_TEN), 0, 0};
		dir_tab[23] = '{mk_load(1, -Q_ONE, 0, 0, Q_TEN), 0, 0};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[r])
			send_item(dir_tab[r].it, dir_tab[r].typed, dir_tab[r].vis);

		for (int i = 0; i < RAND_ITEMS; i++) begin
			steady = (i >= 200 && i < 330);
			if (i == 400) begin
				// hold the sender until the output side has drained
				in_valid = 1'b0;
				while (verdicts_due.size() != 0) @(negedge clk);
			end
			send_item(random_item(), 0, 0);
		end
		in_valid = 1'b0;
		steady   = 1'b0;

		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("frustum_box_cull_test: match");
		else
			$display("frustum_box_cull_test: mismatch");
		$finish;
	end

endmodule
